// ----- rtl/uart_rb_pkg.sv -----
// Shared definitions for the UART transmit/receive ring buffers.
// Holds command codes, register indexes, field widths and the
// controller/datapath handshake structs. No dependencies.
package uart_rb_pkg;

    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int TX_FILL_W  = 11;
    localparam int RX_FILL_W  = 8;
    localparam int RX_RAW_W   = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam int MIN_RING   = 16;
    localparam int TX_MARGIN  = 2;

    localparam logic [CMD_W-1:0] CMD_TX_PUT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TX_EMPTY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RX_POP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RX_PEEK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RX_CLEAR = 3'd5;
    localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_TX_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_SIZE = 1'b1;

    typedef struct packed {
        logic load;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } ctl_sts_t;

    // first member lands in the highest bits; send_valid ends up at bit 0
    typedef struct packed {
        logic [RX_FILL_W-1:0] rx_fill;
        logic [TX_FILL_W-1:0] tx_fill;
        logic                 tx_irq_enabled;
        logic                 accepted;
        logic [BYTE_W-1:0]    read_byte;
        logic [BYTE_W-1:0]    send_byte;
        logic                 send_valid;
    } result_t;

endpackage

// ----- rtl/uart_tx_rx_ring_buffers.sv -----
// Top level of the UART transmit/receive ring buffers.
// Depends on uart_rb_pkg, uart_rb_ctrl, uart_rb_dp, uart_rb_pack, uart_rb_ram.
//
// Usage:
//   s_ channel carries one command transaction: s_tuser is the command
//   (tx put, tx empty event, rx byte, rx pop, rx peek, rx clear, status),
//   s_tdata the byte and its parity/framing error flags.
//   m_ channel returns one result transaction per command with the sent
//   byte, read byte, accept flag, interrupt enable and both fill levels.
//   cfg_we/cfg_index/cfg_wdata set the ring sizes; only the first nonzero
//   write to each size takes effect, and it empties that ring.
// Timing:
//   A command is taken in the idle state, where the ring RAM read is issued;
//   the controller commits it in the exec state, registering the result.
//   A new command is taken only once the last one is committed.
//   While m_tready is low the result holds and one further command may
//   be taken; its execution waits until the result register frees.
// Reset: aresetn (synchronous, active low) empties both rings, clears the
//   interrupt enable and both sizes (rings unallocated). RAM contents are
//   not cleared; no clearing pass is needed.
module uart_tx_rx_ring_buffers #(
    parameter int TX_CAPACITY = 1024,
    parameter int RX_CAPACITY = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [7:0] data_byte, [8] parity_error, [9] framing_error, [15:10] zero
    input  logic [uart_rb_pkg::S_TDATA_W-1:0]      s_tdata,
    // [2:0] command
    input  logic [uart_rb_pkg::CMD_W-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [0] send_valid, [8:1] send_byte, [16:9] read_byte, [17] accepted,
    // [18] tx_irq_enabled, [29:19] tx_fill, [37:30] rx_fill, [39:38] zero
    output logic [uart_rb_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                   cfg_we,
    input  logic [uart_rb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [uart_rb_pkg::CFG_W-1:0]          cfg_wdata
);
    import uart_rb_pkg::*;

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;
    result_t  result;

    uart_rb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    uart_rb_dp #(
        .TX_CAPACITY (TX_CAPACITY),
        .RX_CAPACITY (RX_CAPACITY)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (ctl_cmd),
        .sts              (ctl_sts),
        .in_command       (s_tuser),
        .in_data_byte     (s_tdata[BYTE_W-1:0]),
        .in_parity_error  (s_tdata[BYTE_W]),
        .in_framing_error (s_tdata[BYTE_W+1]),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_result       (result)
    );

    uart_rb_pack u_pack (
        .result (result),
        .tdata  (m_tdata)
    );

endmodule

// ----- rtl/uart_rb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for both ring stores. No dependencies.
module uart_rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/uart_rb_ctrl.sv -----
// Transaction sequencer for the UART ring buffers.
// Depends on uart_rb_pkg; drives load/commit commands into uart_rb_dp.
module uart_rb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  uart_rb_pkg::ctl_sts_t sts,
    output uart_rb_pkg::ctl_cmd_t cmd
);
    import uart_rb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (!sts.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/uart_rb_dp.sv -----
// Datapath for the UART ring buffers: size registers, ring pointers,
// fill levels, interrupt enable, both ring RAMs and the output register.
// Depends on uart_rb_pkg and uart_rb_ram.
module uart_rb_dp #(
    parameter int TX_CAPACITY = 1024,
    parameter int RX_CAPACITY = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  uart_rb_pkg::ctl_cmd_t                 cmd,
    output uart_rb_pkg::ctl_sts_t                 sts,
    input  logic [uart_rb_pkg::CMD_W-1:0]         in_command,
    input  logic [uart_rb_pkg::BYTE_W-1:0]        in_data_byte,
    input  logic                                  in_parity_error,
    input  logic                                  in_framing_error,
    input  logic                                  cfg_we,
    input  logic [uart_rb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uart_rb_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output uart_rb_pkg::result_t                  out_result
);
    import uart_rb_pkg::*;

    localparam int TXA_W = $clog2(TX_CAPACITY);
    localparam int TXS_W = $clog2(TX_CAPACITY + 1);
    localparam int TXE_W = (TXS_W > CFG_W) ? TXS_W : CFG_W;
    localparam int RXA_W = $clog2(RX_CAPACITY);
    localparam int RXS_W = $clog2(RX_CAPACITY + 1);
    localparam int RXE_W = (RXS_W > RX_RAW_W) ? RXS_W : RX_RAW_W;

    function automatic logic [TXS_W-1:0] tx_eff(input logic [CFG_W-1:0] raw);
        logic [TXE_W-1:0] r;
        r = TXE_W'(raw);
        if (raw == '0) begin
            return '0;
        end else if (r < TXE_W'(MIN_RING)) begin
            return TXS_W'(MIN_RING);
        end else if (r > TXE_W'(TX_CAPACITY)) begin
            return TXS_W'(TX_CAPACITY);
        end
        return r[TXS_W-1:0];
    endfunction

    function automatic logic [RXS_W-1:0] rx_eff(input logic [RX_RAW_W-1:0] raw);
        logic [RXE_W-1:0] r;
        r = RXE_W'(raw);
        if (raw == '0) begin
            return '0;
        end else if (r < RXE_W'(MIN_RING)) begin
            return RXS_W'(MIN_RING);
        end else if (r > RXE_W'(RX_CAPACITY)) begin
            return RXS_W'(RX_CAPACITY);
        end
        return r[RXS_W-1:0];
    endfunction

    function automatic logic [TXA_W-1:0] tx_inc(input logic [TXA_W-1:0] p,
                                                input logic [TXS_W-1:0] sz);
        if (TXS_W'(p) == sz - TXS_W'(1)) begin
            return '0;
        end
        return p + TXA_W'(1);
    endfunction

    function automatic logic [RXA_W-1:0] rx_inc(input logic [RXA_W-1:0] p,
                                                input logic [RXS_W-1:0] sz);
        if (RXS_W'(p) == sz - RXS_W'(1)) begin
            return '0;
        end
        return p + RXA_W'(1);
    endfunction

    logic [CMD_W-1:0]  cmd_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              bad_reg;

    logic [TXS_W-1:0] txs_reg, txs_next;
    logic [RXS_W-1:0] rxs_reg, rxs_next;
    logic [TXA_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [TXS_W-1:0] tx_level_reg, tx_level_next;
    logic [RXA_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [RXS_W-1:0] rx_level_reg, rx_level_next;
    logic             irq_reg, irq_next;
    logic             out_valid_reg, out_valid_next;
    result_t          result_reg, result_next;

    logic              tx_we, rx_we;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;

    uart_rb_ram #(.WIDTH(BYTE_W), .DEPTH(TX_CAPACITY)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_tail_reg),
        .wdata (data_reg),
        .re    (cmd.load),
        .raddr (tx_head_reg),
        .rdata (tx_rdata)
    );

    uart_rb_ram #(.WIDTH(BYTE_W), .DEPTH(RX_CAPACITY)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_tail_reg),
        .wdata (data_reg),
        .re    (cmd.load),
        .raddr (rx_head_reg),
        .rdata (rx_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= in_command;
            data_reg <= in_data_byte;
            bad_reg  <= in_parity_error | in_framing_error;
        end
    end

    always_comb begin
        logic tx_alloc;
        logic rx_alloc;
        logic rx_has;
        tx_alloc = (txs_reg != '0);
        rx_alloc = (rxs_reg != '0);
        rx_has   = rx_alloc && (rx_level_reg != '0);

        txs_next      = txs_reg;
        rxs_next      = rxs_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_level_next = tx_level_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_level_next = rx_level_reg;
        irq_next      = irq_reg;
        tx_we         = 1'b0;
        rx_we         = 1'b0;
        result_next   = result_reg;

        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TX_SIZE: begin
                    if (!tx_alloc) begin
                        txs_next      = tx_eff(cfg_wdata);
                        tx_head_next  = '0;
                        tx_tail_next  = '0;
                        tx_level_next = '0;
                    end
                end
                CFG_RX_SIZE: begin
                    if (!rx_alloc) begin
                        rxs_next      = rx_eff(cfg_wdata[RX_RAW_W-1:0]);
                        rx_head_next  = '0;
                        rx_tail_next  = '0;
                        rx_level_next = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.commit) begin
            result_next.send_valid = 1'b0;
            result_next.send_byte  = '0;
            result_next.read_byte  = '0;
            result_next.accepted   = 1'b0;
            unique case (cmd_reg)
                CMD_TX_PUT: begin
                    if (tx_alloc && tx_level_reg <= txs_reg - TXS_W'(TX_MARGIN)) begin
                        tx_we                = 1'b1;
                        tx_tail_next         = tx_inc(tx_tail_reg, txs_reg);
                        tx_level_next        = tx_level_reg + TXS_W'(1);
                        result_next.accepted = 1'b1;
                        irq_next             = 1'b1;
                    end
                end
                CMD_TX_EMPTY: begin
                    if (!tx_alloc || tx_level_reg == '0) begin
                        irq_next = 1'b0;
                    end else begin
                        result_next.send_valid = 1'b1;
                        result_next.send_byte  = tx_rdata;
                        tx_head_next           = tx_inc(tx_head_reg, txs_reg);
                        tx_level_next          = tx_level_reg - TXS_W'(1);
                    end
                end
                CMD_RX_BYTE: begin
                    if (!bad_reg && rx_alloc && rx_level_reg < rxs_reg) begin
                        rx_we                = 1'b1;
                        rx_tail_next         = rx_inc(rx_tail_reg, rxs_reg);
                        rx_level_next        = rx_level_reg + RXS_W'(1);
                        result_next.accepted = 1'b1;
                    end
                end
                CMD_RX_POP: begin
                    if (rx_has) begin
                        result_next.read_byte = rx_rdata;
                        rx_head_next          = rx_inc(rx_head_reg, rxs_reg);
                        rx_level_next         = rx_level_reg - RXS_W'(1);
                    end
                end
                CMD_RX_PEEK: begin
                    if (rx_has) begin
                        result_next.read_byte = rx_rdata;
                    end
                end
                CMD_RX_CLEAR: begin
                    rx_head_next  = '0;
                    rx_tail_next  = '0;
                    rx_level_next = '0;
                end
                default: begin
                end
            endcase
            result_next.tx_irq_enabled = irq_next;
            result_next.tx_fill        = TX_FILL_W'(tx_level_next);
            result_next.rx_fill        = RX_FILL_W'(rx_level_next);
            out_valid_next             = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txs_reg       <= '0;
            rxs_reg       <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_level_reg  <= '0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_level_reg  <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            txs_reg       <= txs_next;
            rxs_reg       <= rxs_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_level_reg  <= tx_level_next;
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_level_reg  <= rx_level_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign sts.out_stall = out_valid_reg & ~out_ready;
    assign out_valid     = out_valid_reg;
    assign out_result    = result_reg;

endmodule

// ----- rtl/uart_rb_top_unused_guard.sv -----
// Output-side packing stage for the UART ring buffers.
// Depends on uart_rb_pkg; maps the result struct onto the m_tdata bus.
module uart_rb_pack (
    input  uart_rb_pkg::result_t                   result,
    output logic [uart_rb_pkg::M_TDATA_W-1:0]      tdata
);
    import uart_rb_pkg::*;

    localparam int PAD_W = M_TDATA_W - $bits(result_t);

    assign tdata = {{PAD_W{1'b0}}, result};

endmodule

// ----- dv/tb_top.sv -----
// Testbench for uart_tx_rx_ring_buffers: directed and random UART ring commands
// checked field by field against an in-bench ring model, with bursty input and
// receiver back-pressure. Depends on uart_rb_pkg and the RTL under rtl/.
module tb_top;
    import uart_rb_pkg::*;

    localparam int TX_CAP = 1024;
    localparam int RX_CAP = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT = 300;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
        logic              par;
        logic              frm;
        bit                typed;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // ring model state
    logic [CFG_W-1:0]  tx_size_reg = '0;
    logic [7:0]        rx_size_reg = '0;
    logic [BYTE_W-1:0] tx_mem [TX_CAP];
    logic [BYTE_W-1:0] rx_mem [RX_CAP];
    int unsigned       tx_rd, tx_wr, tx_cnt, rx_rd, rx_wr, rx_cnt;
    logic              irq_en = 1'b0;

    result_t   pending_results [$];
    stim_row_t drills [$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        tx_full_hits = 0;
    int        rx_full_hits = 0;
    int        errored_bytes = 0;
    int        stall_cycles = 0;
    bit        hold_done = 1'b0;

    // columns follow the command encoding; cumulative percent
    int unsigned mix_cut [3][8] = '{
        '{35, 43, 83, 90, 94, 95, 98, 100},
        '{10, 40, 50, 85, 92, 94, 98, 100},
        '{25, 50, 72, 88, 94, 96, 98, 100}
    };

    uart_tx_rx_ring_buffers #(
        .TX_CAPACITY(TX_CAP),
        .RX_CAPACITY(RX_CAP)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned ring_span(int unsigned sz, int unsigned cap);
        if (sz == 0) return 0;
        if (sz < MIN_RING) sz = MIN_RING;
        if (sz > cap) sz = cap;
        return sz;
    endfunction

    function automatic result_t uart_rings_next(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                                logic bad);
        result_t     r;
        int unsigned txs;
        int unsigned rxs;
        r = '0;
        txs = ring_span(tx_size_reg, TX_CAP);
        rxs = ring_span(rx_size_reg, RX_CAP);
        case (cmd)
            CMD_TX_PUT: begin
                if (txs != 0 && tx_cnt <= txs - TX_MARGIN) begin
                    tx_mem[tx_wr] = data;
                    tx_wr = (tx_wr + 1) % txs;
                    tx_cnt++;
                    r.accepted = 1'b1;
                    irq_en = 1'b1;
                end else if (txs != 0) begin
                    tx_full_hits++;
                end
            end
            CMD_TX_EMPTY: begin
                if (txs == 0 || tx_cnt == 0) begin
                    irq_en = 1'b0;
                end else begin
                    r.send_valid = 1'b1;
                    r.send_byte = tx_mem[tx_rd];
                    tx_rd = (tx_rd + 1) % txs;
                    tx_cnt--;
                end
            end
            CMD_RX_BYTE: begin
                if (bad) begin
                    errored_bytes++;
                end else if (rxs != 0 && rx_cnt < rxs) begin
                    rx_mem[rx_wr] = data;
                    rx_wr = (rx_wr + 1) % rxs;
                    rx_cnt++;
                    r.accepted = 1'b1;
                end else if (rxs != 0) begin
                    rx_full_hits++;
                end
            end
            CMD_RX_POP: begin
                if (rxs != 0 && rx_cnt != 0) begin
                    r.read_byte = rx_mem[rx_rd];
                    rx_rd = (rx_rd + 1) % rxs;
                    rx_cnt--;
                end
            end
            CMD_RX_PEEK: begin
                if (rxs != 0 && rx_cnt != 0) r.read_byte = rx_mem[rx_rd];
            end
            CMD_RX_CLEAR: begin
                rx_rd = 0;
                rx_wr = 0;
                rx_cnt = 0;
            end
            default: ;
        endcase
        r.tx_irq_enabled = irq_en;
        r.tx_fill = TX_FILL_W'(tx_cnt);
        r.rx_fill = RX_FILL_W'(rx_cnt);
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                         logic par, logic frm, bit typed);
        stim_row_t row;
        row.cmd = cmd;
        row.data = data;
        row.par = par;
        row.frm = frm;
        row.typed = typed;
        return row;
    endfunction

    task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("mismatch %0d at %0t: %s got %0h want %0h", mismatches, $realtime, what, got,
                 want);
    endtask

    // offer one transaction and record its expected result once taken
    task automatic offer(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data, logic par, logic frm,
                         bit typed);
        result_t want;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_W - BYTE_W - 2){1'b0}}, frm, par, data};
        do @(posedge aclk); while (!s_tready);
        want = uart_rings_next(cmd, data, par | frm);
        pending_results.push_back(typed ? result_t'('0) : want);
        items_sent++;
    endtask

    task automatic idle(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic quiesce();
        idle(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TX_SIZE) begin
            if (tx_size_reg == 0) begin
                tx_size_reg = value;
                tx_rd = 0;
                tx_wr = 0;
                tx_cnt = 0;
            end
        end else if (rx_size_reg == 0) begin
            rx_size_reg = value[7:0];
            rx_rd = 0;
            rx_wr = 0;
            rx_cnt = 0;
        end
        @(posedge aclk);
    endtask

    task automatic offer_random(int mode);
        int unsigned      pick;
        int               k;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        k = 0;
        while (pick >= mix_cut[mode][k]) k++;
        cmd = CMD_W'(k);
        offer(cmd, BYTE_W'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
              1'b0);
    endtask

    task automatic run_random(int total);
        int left;
        int burst;
        int block_left;
        int mode;
        left = total;
        block_left = 0;
        mode = 0;
        while (left > 0) begin
            if (block_left <= 0) begin
                block_left = $urandom_range(40, 120);
                mode = $urandom_range(0, 2);
            end
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0) begin
                offer_random(mode);
                burst--;
                left--;
                block_left--;
            end
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
        end
    endtask

    // receiver: rotating stall patterns, plus one long hold-off to back up the input
    initial begin
        logic [31:0] pattern;
        int          slot;
        slot = 0;
        pattern = '1;
        forever begin
            @(posedge aclk);
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (slot % 48 == 0) begin
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = $urandom;
                        2: pattern = $urandom | $urandom;
                        default: pattern = $urandom & $urandom;
                    endcase
                end
                m_tready <= pattern[slot % 32];
                slot++;
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.send_valid !== want.send_valid)
                    note_mismatch("send_valid", got.send_valid, want.send_valid);
                if (got.send_byte !== want.send_byte)
                    note_mismatch("send_byte", got.send_byte, want.send_byte);
                if (got.read_byte !== want.read_byte)
                    note_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.accepted !== want.accepted)
                    note_mismatch("accepted", got.accepted, want.accepted);
                if (got.tx_irq_enabled !== want.tx_irq_enabled)
                    note_mismatch("tx_irq_enabled", got.tx_irq_enabled, want.tx_irq_enabled);
                if (got.tx_fill !== want.tx_fill)
                    note_mismatch("tx_fill", got.tx_fill, want.tx_fill);
                if (got.rx_fill !== want.rx_fill)
                    note_mismatch("rx_fill", got.rx_fill, want.rx_fill);
                if (m_tdata[M_TDATA_W-1:$bits(result_t)] !== '0)
                    note_mismatch("pad", m_tdata[M_TDATA_W-1:$bits(result_t)], 0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int alloc_row;
        alloc_row = 9;
        // rings unallocated: every output reads zero
        drills.push_back(mk_row(CMD_TX_PUT, 8'hFF, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_TX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'hA5, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'h5A, 1'b1, 1'b1, 1'b1));
        drills.push_back(mk_row(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_RX_PEEK, 8'h00, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_RX_CLEAR, 8'h00, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_STATUS, 8'h00, 1'b0, 1'b0, 1'b1));
        drills.push_back(mk_row(CMD_RESERVED, 8'hFF, 1'b1, 1'b1, 1'b1));
        // rings allocated
        drills.push_back(mk_row(CMD_TX_PUT, 8'h00, 1'b1, 1'b1, 1'b0));
        drills.push_back(mk_row(CMD_TX_PUT, 8'hFF, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_TX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_TX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_TX_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'h3C, 1'b1, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'h3C, 1'b0, 1'b1, 1'b0));
        drills.push_back(mk_row(CMD_RX_PEEK, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_POP, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_BYTE, 8'h81, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RX_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0));
        drills.push_back(mk_row(CMD_RESERVED, 8'h00, 1'b0, 1'b0, 1'b0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_size(CFG_TX_SIZE, '0);
        write_size(CFG_RX_SIZE, '0);

        for (int i = 0; i < drills.size(); i++) begin
            if (i == alloc_row) begin
                quiesce();
                write_size(CFG_TX_SIZE, CFG_W'($urandom_range(1, 24)));
                write_size(CFG_RX_SIZE, CFG_W'($urandom_range(1, 24)));
            end
            offer(drills[i].cmd, drills[i].data, drills[i].par, drills[i].frm, drills[i].typed);
        end

        quiesce();
        run_random(550);
        quiesce();
        // sizes are fixed once allocated; these writes must be ignored
        write_size(CFG_TX_SIZE, '1);
        write_size(CFG_RX_SIZE, CFG_W'(255));
        run_random(550);

        idle(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch("results left over", pending_results.size(), 0);

        $display("%0d commands, %0d results checked; ring sizes tx %0d rx %0d", items_sent,
                 results_seen, tx_size_reg, rx_size_reg);
        $display("tx full %0d times, rx full %0d times, %0d errored bytes dropped",
                 tx_full_hits, rx_full_hits, errored_bytes);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
